@@ src/sor_pkg.sv @@
package sor_pkg;

   // Fixed-point format of the stencil arithmetic.
   localparam int WORD_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // Field and register widths.
   localparam int FIELD_W   = 32;
   localparam int COEFF_W   = 2 * FIELD_W;
   localparam int OMEGA_W   = 18;
   localparam int ITS_W     = 32;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] REG_RELAX  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INV_DT = 1'd1;

   localparam logic [OMEGA_W-1:0] RELAX_RESET  = OMEGA_W'(1 << FRAC_BITS);
   localparam logic [ITS_W-1:0]   INV_DT_RESET = ITS_W'(1 << FRAC_BITS);

   // Datapath widths.
   localparam int WT_W     = FIELD_W + 2;        // 2*ci +/- cj, and c1+c2+c3
   localparam int PROD_W   = WT_W + FIELD_W;     // one weighted neighbor term
   localparam int ACC_W    = PROD_W + 2;         // sum of seven terms
   localparam int MAG_W    = ACC_W - 1;
   localparam int DIV_W    = FIELD_W + 3;        // 4*|c1+c2+c3|
   localparam int CAP_BIT  = WORD_WIDTH + FRAC_BITS + 1;
   localparam int HUGE_BIT = WORD_WIDTH + FRAC_BITS;
   localparam int Q_W      = CAP_BIT;
   localparam int TOP_W    = MAG_W - Q_W;
   localparam int CORR_W   = ((CAP_BIT > FIELD_W) ? CAP_BIT : FIELD_W) + 2;

   localparam int DIV_STEPS  = 7;
   localparam int DIV_STAGES = (Q_W + DIV_STEPS - 1) / DIV_STEPS;

   localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);

   typedef struct packed {
      logic signed [FIELD_W-1:0] p_center;
      logic signed [FIELD_W-1:0] p_east;
      logic signed [FIELD_W-1:0] p_west;
      logic signed [FIELD_W-1:0] p_north;
      logic signed [FIELD_W-1:0] p_south;
      logic signed [FIELD_W-1:0] p_top;
      logic signed [FIELD_W-1:0] p_bottom;
      logic [COEFF_W-1:0]        coeff_x;
      logic [COEFF_W-1:0]        coeff_y;
      logic [COEFF_W-1:0]        coeff_z;
      logic signed [FIELD_W-1:0] divergence;
   } sor_req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] new_pressure;
      logic [FIELD_W-1:0]        correction_squared;
      logic                      divide_fault;
      logic                      saturated;
   } sor_rsp_type;

   // Fields that ride along the divider untouched.
   typedef struct packed {
      logic signed [FIELD_W-1:0] pc;
      logic                      fault;
      logic                      qneg;
   } sor_side_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic [DIV_W-1:0] dmag;
      sor_side_type     side;
   } sor_div_in_type;

   typedef struct packed {
      logic [Q_W:0] q;
      sor_side_type side;
   } sor_div_out_type;

endpackage

@@ src/sor_divider.sv @@
module sor_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     adv,
   input  logic                     in_valid,
   input  sor_pkg::sor_div_in_type  in_data,
   output logic                     out_valid,
   output sor_pkg::sor_div_out_type out_data
);
   import sor_pkg::*;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [Q_W-1:0]   wq;      // dividend bits not yet used, quotient bits shifted in
      logic [DIV_W-1:0] dmag;
      logic             ovf;
      sor_side_type     side;
   } div_state_type;

   // Restoring division steps; a step past the last quotient bit passes through.
   function automatic div_state_type run_steps(input div_state_type s, input int base);
      logic [DIV_W:0] t;
      div_state_type  r;
      r = s;
      for (int j = 0; j < DIV_STEPS; j++) begin
         if (base + j < Q_W) begin
            t = {r.rem, r.wq[Q_W-1]};
            if (t >= {1'b0, r.dmag}) begin
               t = t - {1'b0, r.dmag};
               r.wq = {r.wq[Q_W-2:0], 1'b1};
            end else begin
               r.wq = {r.wq[Q_W-2:0], 1'b0};
            end
            r.rem = t[DIV_W-1:0];
         end
      end
      return r;
   endfunction

   div_state_type   init_ff, init_in;
   div_state_type   stage_ff [DIV_STAGES];
   div_state_type   step_in  [DIV_STAGES];
   logic [DIV_STAGES:0] vld_ff;
   sor_div_out_type out_ff, out_in;
   logic            out_vld_ff;
   logic [TOP_W-1:0] top;
   logic             half;
   div_state_type    last;

   // The quotient saturates when the top dividend bits already reach the divisor.
   always_comb begin
      top          = in_data.mag[MAG_W-1:Q_W];
      init_in.rem  = DIV_W'(top);
      init_in.wq   = in_data.mag[Q_W-1:0];
      init_in.dmag = in_data.dmag;
      init_in.ovf  = DIV_W'(top) >= in_data.dmag;
      init_in.side = in_data.side;
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign step_in[s] = run_steps(init_ff, 0);
      end else begin : g_next
         assign step_in[s] = run_steps(stage_ff[s-1], s * DIV_STEPS);
      end
      always_ff @(posedge clock) begin
         if (adv) stage_ff[s] <= step_in[s];
      end
   end

   always_comb begin
      last = stage_ff[DIV_STAGES-1];
      half = {last.rem, 1'b0} >= {1'b0, last.dmag};
      out_in.side = last.side;
      if (last.ovf) begin
         out_in.q = {1'b1, {Q_W{1'b0}}};
      end else begin
         out_in.q = {1'b0, last.wq} + (Q_W+1)'(half);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         init_ff <= init_in;
         out_ff  <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[DIV_STAGES-1:0], in_valid};
         out_vld_ff <= vld_ff[DIV_STAGES];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_data  = out_ff;

endmodule

@@ src/sor_stencil_point_update.sv @@
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | sor_req_type
// rsp     | out       | rsp_valid / rsp_ready | sor_rsp_type
// csr     | in        | csr_we                | csr_index, csr_wdata
//
// One item is taken per cycle while no result is held at the output.
// Nine of its stages are the 49-bit restoring divide, seven stages of seven steps.
// Reset is synchronous: it empties the pipeline and sets both registers to 1.0.
// A held result freezes every stage and drops req_ready; no item is lost.
module sor_stencil_point_update (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  sor_pkg::sor_req_type          req_item,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sor_pkg::sor_rsp_type          rsp_item,
   input  logic                          csr_we,
   input  logic [sor_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sor_pkg::CSR_W-1:0]     csr_wdata
);
   import sor_pkg::*;

   localparam int SPLIT = CORR_W / 2;
   localparam int PRD_W = CORR_W + OMEGA_W + 1;
   localparam int SQ_W  = 2 * FIELD_W;

   localparam logic signed [PRD_W-1:0] NP_MAX = (PRD_W'(1) << (WORD_WIDTH - 1)) - PRD_W'(1);
   localparam logic signed [PRD_W-1:0] NP_MIN = ~NP_MAX;
   localparam logic [FIELD_W-1:0]      SQ_MAX = FIELD_W'((65'd1 << WORD_WIDTH) - 65'd1);

   typedef struct packed {
      logic signed [FIELD_W-1:0]  pc;
      logic [5:0][FIELD_W-1:0]    p;
      logic [5:0][WT_W-1:0]       w;
      logic signed [WT_W-1:0]     csum;
      logic signed [FIELD_W-1:0]  dv;
   } s1_type;

   typedef struct packed {
      logic [5:0][PROD_W-1:0]     t;
      logic [PROD_W-1:0]          rhs2;
      logic [DIV_W-1:0]           dmag;
      logic                       dneg;
      logic                       zero;
      logic signed [FIELD_W-1:0]  pc;
   } s2_type;

   typedef struct packed {
      logic signed [ACC_W-1:0]    s0;
      logic signed [ACC_W-1:0]    s1;
      logic [DIV_W-1:0]           dmag;
      logic                       dneg;
      logic                       zero;
      logic signed [FIELD_W-1:0]  pc;
   } s3_type;

   typedef struct packed {
      logic signed [ACC_W-1:0]    acc;
      logic [DIV_W-1:0]           dmag;
      logic                       dneg;
      logic                       zero;
      logic signed [FIELD_W-1:0]  pc;
   } s4_type;

   typedef struct packed {
      logic signed [CORR_W-1:0]   corr;
      logic signed [FIELD_W-1:0]  pc;
      logic                       fault;
   } sc_type;

   typedef struct packed {
      logic [OMEGA_W+SPLIT-1:0]          pa;
      logic signed [OMEGA_W+CORR_W-SPLIT:0] pb;
      logic [FIELD_W-1:0]                msq;
      logic                              big;
      logic                              huge;
      logic                              cneg;
      logic signed [FIELD_W-1:0]         pc;
      logic                              fault;
   } m1_type;

   typedef struct packed {
      logic [SQ_W-1:0]            sqp;
      logic signed [PRD_W-1:0]    prod;
      logic                       big;
      logic                       huge;
      logic                       cneg;
      logic signed [FIELD_W-1:0]  pc;
      logic                       fault;
   } m2_type;

   typedef struct packed {
      logic [FIELD_W-1:0]         sq_lo;
      logic                       sq_clip;
      logic signed [PRD_W-1:0]    pr;
      logic                       huge;
      logic                       cneg;
      logic signed [FIELD_W-1:0]  pc;
      logic                       fault;
   } m3_type;

   logic [OMEGA_W-1:0] relax_ff;
   logic [ITS_W-1:0]   inv_dt_ff;

   s1_type          s1_ff, s1_in;
   s2_type          s2_ff, s2_in;
   s3_type          s3_ff, s3_in;
   s4_type          s4_ff, s4_in;
   sor_div_in_type  s5_ff, s5_in;
   sc_type          sc_ff, sc_in;
   m1_type          m1_ff, m1_in;
   m2_type          m2_ff, m2_in;
   m3_type          m3_ff, m3_in;
   sor_rsp_type     rsp_ff, rsp_in;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, vc_ff, vm1_ff, vm2_ff, vm3_ff, rsp_valid_ff;

   logic                      adv;
   logic                      div_valid;
   sor_div_out_type           div_out;

   logic signed [FIELD_W-1:0] cd1, cd2, cd3, ca1, ca2, ca3;
   logic signed [ITS_W:0]     its_s;
   logic signed [FIELD_W+ITS_W:0] rhs_p;
   logic [WT_W-1:0]           cabs;
   logic [ACC_W-1:0]          mag_full;
   logic signed [CORR_W-1:0]  qx;
   logic [CORR_W-1:0]         mabs;
   logic [SQ_W:0]             sq_sum;
   logic [SQ_W:0]             sq_r;
   logic signed [PRD_W-1:0]   pr_sum;
   logic signed [PRD_W-1:0]   np_sum;
   logic                      np_clip;

   // The whole pipeline moves together whenever the output register can take a result.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         relax_ff  <= RELAX_RESET;
         inv_dt_ff <= INV_DT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RELAX:  relax_ff  <= csr_wdata[OMEGA_W-1:0];
            REG_INV_DT: inv_dt_ff <= csr_wdata[ITS_W-1:0];
            default:    ;
         endcase
      end
   end

   // Stage 1: stencil weights held exactly as 2*ci +/- cj.
   always_comb begin
      cd1 = signed'(req_item.coeff_x[FIELD_W-1:0]);
      cd2 = signed'(req_item.coeff_y[FIELD_W-1:0]);
      cd3 = signed'(req_item.coeff_z[FIELD_W-1:0]);
      ca1 = signed'(req_item.coeff_x[COEFF_W-1:FIELD_W]);
      ca2 = signed'(req_item.coeff_y[COEFF_W-1:FIELD_W]);
      ca3 = signed'(req_item.coeff_z[COEFF_W-1:FIELD_W]);
      s1_in.pc   = req_item.p_center;
      s1_in.p[0] = req_item.p_east;
      s1_in.p[1] = req_item.p_west;
      s1_in.p[2] = req_item.p_north;
      s1_in.p[3] = req_item.p_south;
      s1_in.p[4] = req_item.p_top;
      s1_in.p[5] = req_item.p_bottom;
      s1_in.w[0] = (WT_W'(cd1) <<< 1) + WT_W'(ca1);
      s1_in.w[1] = (WT_W'(cd1) <<< 1) - WT_W'(ca1);
      s1_in.w[2] = (WT_W'(cd2) <<< 1) + WT_W'(ca2);
      s1_in.w[3] = (WT_W'(cd2) <<< 1) - WT_W'(ca2);
      s1_in.w[4] = (WT_W'(cd3) <<< 1) + WT_W'(ca3);
      s1_in.w[5] = (WT_W'(cd3) <<< 1) - WT_W'(ca3);
      s1_in.csum = WT_W'(cd1) + WT_W'(cd2) + WT_W'(cd3);
      s1_in.dv   = req_item.divergence;
   end

   // Stage 2: products, and the divisor 2*center = -4*(c1+c2+c3) as sign and magnitude.
   always_comb begin
      its_s = signed'({1'b0, inv_dt_ff});
      rhs_p = s1_ff.dv * its_s;
      for (int i = 0; i < 6; i++) begin
         s2_in.t[i] = signed'(s1_ff.w[i]) * signed'(s1_ff.p[i]);
      end
      s2_in.rhs2 = {rhs_p, 1'b0};
      cabs       = s1_ff.csum[WT_W-1] ? -s1_ff.csum : s1_ff.csum;
      s2_in.dmag = {cabs[DIV_W-3:0], 2'b00};
      s2_in.dneg = !s1_ff.csum[WT_W-1] && (s1_ff.csum != '0);
      s2_in.zero = s1_ff.csum == '0;
      s2_in.pc   = s1_ff.pc;
   end

   always_comb begin
      s3_in.s0 = ACC_W'(signed'(s2_ff.rhs2)) - ACC_W'(signed'(s2_ff.t[0]))
                 - ACC_W'(signed'(s2_ff.t[1])) - ACC_W'(signed'(s2_ff.t[2]));
      s3_in.s1 = -ACC_W'(signed'(s2_ff.t[3])) - ACC_W'(signed'(s2_ff.t[4]))
                 - ACC_W'(signed'(s2_ff.t[5]));
      s3_in.dmag = s2_ff.dmag;
      s3_in.dneg = s2_ff.dneg;
      s3_in.zero = s2_ff.zero;
      s3_in.pc   = s2_ff.pc;
   end

   always_comb begin
      s4_in.acc  = s3_ff.s0 + s3_ff.s1;
      s4_in.dmag = s3_ff.dmag;
      s4_in.dneg = s3_ff.dneg;
      s4_in.zero = s3_ff.zero;
      s4_in.pc   = s3_ff.pc;
   end

   always_comb begin
      mag_full        = s4_ff.acc[ACC_W-1] ? -s4_ff.acc : s4_ff.acc;
      s5_in.mag       = mag_full[MAG_W-1:0];
      s5_in.dmag      = s4_ff.dmag;
      s5_in.side.pc   = s4_ff.pc;
      s5_in.side.fault = s4_ff.zero;
      s5_in.side.qneg = s4_ff.acc[ACC_W-1] ^ s4_ff.dneg;
   end

   sor_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .in_data   (s5_ff),
      .out_valid (div_valid),
      .out_data  (div_out)
   );

   always_comb begin
      qx          = signed'(CORR_W'(div_out.q));
      sc_in.corr  = (div_out.side.qneg ? -qx : qx) - CORR_W'(div_out.side.pc);
      sc_in.pc    = div_out.side.pc;
      sc_in.fault = div_out.side.fault;
   end

   // omega*corr is split into two narrower products, joined in the next stage.
   always_comb begin
      mabs     = sc_ff.corr[CORR_W-1] ? -sc_ff.corr : sc_ff.corr;
      m1_in.pa = relax_ff * sc_ff.corr[SPLIT-1:0];
      m1_in.pb = signed'({1'b0, relax_ff}) * signed'(sc_ff.corr[CORR_W-1:SPLIT]);
      m1_in.msq   = mabs[FIELD_W-1:0];
      m1_in.big   = |mabs[CORR_W-1:FIELD_W];
      m1_in.huge  = |mabs[CORR_W-1:HUGE_BIT];
      m1_in.cneg  = sc_ff.corr[CORR_W-1];
      m1_in.pc    = sc_ff.pc;
      m1_in.fault = sc_ff.fault;
   end

   always_comb begin
      m2_in.sqp   = m1_ff.msq * m1_ff.msq;
      m2_in.prod  = (PRD_W'(m1_ff.pb) <<< SPLIT) + signed'(PRD_W'(m1_ff.pa));
      m2_in.big   = m1_ff.big;
      m2_in.huge  = m1_ff.huge;
      m2_in.cneg  = m1_ff.cneg;
      m2_in.pc    = m1_ff.pc;
      m2_in.fault = m1_ff.fault;
   end

   always_comb begin
      sq_sum        = {1'b0, m2_ff.sqp} + (SQ_W+1)'(ROUND_HALF);
      sq_r          = sq_sum >> FRAC_BITS;
      m3_in.sq_lo   = sq_r[FIELD_W-1:0];
      m3_in.sq_clip = m2_ff.big || (|sq_r[SQ_W:WORD_WIDTH]);
      pr_sum        = m2_ff.prod + PRD_W'(ROUND_HALF);
      m3_in.pr      = pr_sum >>> FRAC_BITS;
      m3_in.huge    = m2_ff.huge;
      m3_in.cneg    = m2_ff.cneg;
      m3_in.pc      = m2_ff.pc;
      m3_in.fault   = m2_ff.fault;
   end

   // A zero center weight passes the pressure through; a zero omega leaves it too.
   always_comb begin
      np_sum  = m3_ff.pr + PRD_W'(m3_ff.pc);
      np_clip = 1'b0;
      rsp_in.new_pressure       = m3_ff.pc;
      rsp_in.correction_squared = '0;
      rsp_in.divide_fault       = m3_ff.fault;
      rsp_in.saturated          = 1'b0;
      if (!m3_ff.fault) begin
         rsp_in.correction_squared = m3_ff.sq_clip ? SQ_MAX : m3_ff.sq_lo;
         priority if (relax_ff == '0) begin
            rsp_in.new_pressure = m3_ff.pc;
         end else if (m3_ff.huge) begin
            rsp_in.new_pressure = m3_ff.cneg ? NP_MIN[FIELD_W-1:0] : NP_MAX[FIELD_W-1:0];
            np_clip = 1'b1;
         end else if (np_sum > NP_MAX) begin
            rsp_in.new_pressure = NP_MAX[FIELD_W-1:0];
            np_clip = 1'b1;
         end else if (np_sum < NP_MIN) begin
            rsp_in.new_pressure = NP_MIN[FIELD_W-1:0];
            np_clip = 1'b1;
         end else begin
            rsp_in.new_pressure = np_sum[FIELD_W-1:0];
         end
         rsp_in.saturated = m3_ff.sq_clip || np_clip;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         sc_ff  <= sc_in;
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         m3_ff  <= m3_in;
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vm1_ff       <= 1'b0;
         vm2_ff       <= 1'b0;
         vm3_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         vc_ff        <= div_valid;
         vm1_ff       <= vc_ff;
         vm2_ff       <= vm1_ff;
         vm3_ff       <= vm2_ff;
         rsp_valid_ff <= vm3_ff;
      end
   end

endmodule

@@ src/sor_checker.sv @@
module sor_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input sor_pkg::sor_rsp_type rsp_item
);
   import sor_pkg::*;

   // A held result must stop intake, or the pipeline would overrun it.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input accepted while a result is held");

   a_reset_empties: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_fault_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.divide_fault |->
         rsp_item.correction_squared == '0 && !rsp_item.saturated)
      else $error("divide fault item carries a correction or clip flag");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("held result dropped or changed");

endmodule

bind sor_stencil_point_update sor_checker u_sor_checker (.*);
